### hdl/svmab_pkg.sv
package svmab_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int IN_W       = 32;
   localparam int SIGN_W     = 2;
   localparam int DUTY_W     = 12;
   localparam int FULL_SCALE = (1 << DUTY_W) - 1;
   localparam int ONE        = 1 << FRAC_BITS;

   localparam logic [63:0] SQRT3_OV_2_Q32 = 64'd3719550787;
   localparam int C32 = int'((SQRT3_OV_2_Q32 + (64'd1 << (31 - FRAC_BITS)))
                             >> (32 - FRAC_BITS));

   localparam int AL_W  = FRAC_BITS + 2;
   localparam int MUL_W = AL_W + FRAC_BITS + 1;
   localparam int P_W   = FRAC_BITS + 3;
   localparam int T_W   = P_W + DUTY_W;
   localparam int S_W   = T_W + 2;
   localparam int N_W   = S_W - FRAC_BITS + 1;

   localparam logic [SIGN_W-1:0] SIGN_POS = 2'b01;

   typedef enum logic [2:0] {
      SEC_NONE = 3'd0,
      SEC_I    = 3'd1,
      SEC_J    = 3'd2,
      SEC_IJ   = 3'd3,
      SEC_K    = 3'd4,
      SEC_IK   = 3'd5,
      SEC_JK   = 3'd6,
      SEC_ALL  = 3'd7
   } sector_type;

   typedef struct packed {
      logic [SIGN_W-1:0] a;
      logic [SIGN_W-1:0] b;
      logic [SIGN_W-1:0] c;
   } sign_set_type;

   typedef struct packed {
      logic                  valid;
      sector_type            sector;
      logic signed [P_W-1:0] pi;
      logic signed [P_W-1:0] pj;
      logic signed [P_W-1:0] pk;
      sign_set_type          signs;
   } proj_type;

   typedef struct packed {
      logic                  valid;
      sector_type            sector;
      logic signed [T_W-1:0] t1;
      logic signed [T_W-1:0] t2;
      logic signed [S_W-1:0] h;
      sign_set_type          signs;
   } time_type;

endpackage

### hdl/svm_alpha_beta_to_duty.sv
// Channel   Ports                                          Handshake
// -------   --------------------------------------------   ---------------------------
// request   req_alpha_in, req_beta_in, req_current_sign_*   start high, busy low
// result    rsp_duty_a, rsp_duty_b, rsp_duty_c             rsp_valid for one cycle
// config    csr_wdata                                      csr_we high
//
// One beat can be accepted every cycle; busy never rises.
// Each request beat passes through six register stages: clamp, projection,
// active times, zero time, counts and compensation.
// Reset clears the stage valid bits and the dead-time register.
// The receiver cannot stall, so results leave in order with no back pressure.
module svm_alpha_beta_to_duty
   import svmab_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [IN_W-1:0] req_alpha_in,
   input  logic signed [IN_W-1:0] req_beta_in,
   input  logic [SIGN_W-1:0]      req_current_sign_a,
   input  logic [SIGN_W-1:0]      req_current_sign_b,
   input  logic [SIGN_W-1:0]      req_current_sign_c,
   output logic                   rsp_valid,
   output logic [DUTY_W-1:0]      rsp_duty_a,
   output logic [DUTY_W-1:0]      rsp_duty_b,
   output logic [DUTY_W-1:0]      rsp_duty_c,
   input  logic                   csr_we,
   input  logic [DUTY_W-1:0]      csr_wdata
);

   logic [DUTY_W-1:0] dead_time_ff, dead_time_in;
   sign_set_type      signs;
   proj_type          proj;
   time_type          times;
   logic              accept;

   assign busy     = 1'b0;
   assign accept   = start & ~busy;
   assign signs.a  = req_current_sign_a;
   assign signs.b  = req_current_sign_b;
   assign signs.c  = req_current_sign_c;

   always_comb begin
      dead_time_in = dead_time_ff;
      if (csr_we) begin
         dead_time_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_time_ff <= '0;
      end else begin
         dead_time_ff <= dead_time_in;
      end
   end

   svmab_proj u_proj (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .alpha    (req_alpha_in),
      .beta     (req_beta_in),
      .signs    (signs),
      .proj     (proj)
   );

   svmab_times u_times (
      .clock (clock),
      .reset (reset),
      .proj  (proj),
      .times (times)
   );

   svmab_comp u_comp (
      .clock     (clock),
      .reset     (reset),
      .times     (times),
      .dead_time (dead_time_ff),
      .out_valid (rsp_valid),
      .duty_a    (rsp_duty_a),
      .duty_b    (rsp_duty_b),
      .duty_c    (rsp_duty_c)
   );

endmodule

### hdl/svmab_proj.sv
module svmab_proj
   import svmab_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic signed [IN_W-1:0] alpha,
   input  logic signed [IN_W-1:0] beta,
   input  sign_set_type           signs,
   output proj_type               proj
);

   localparam logic signed [IN_W-1:0]  ONE_S  = IN_W'(ONE);
   localparam logic signed [IN_W-1:0]  MONE_S = -IN_W'(ONE);
   localparam logic signed [MUL_W-1:0] C_S    = MUL_W'(C32);

   logic                   v1_ff, v1_in;
   logic signed [AL_W-1:0] al1_ff, al1_in;
   logic signed [AL_W-1:0] be1_ff, be1_in;
   sign_set_type           sg1_ff;
   proj_type               proj_ff, proj_in;

   logic signed [MUL_W-1:0] prod;
   logic signed [AL_W-1:0]  al_m;
   logic signed [AL_W-1:0]  be_h;

   always_comb begin
      v1_in = in_valid;
      if (alpha > ONE_S) begin
         al1_in = AL_W'(ONE_S);
      end else if (alpha < MONE_S) begin
         al1_in = AL_W'(MONE_S);
      end else begin
         al1_in = AL_W'(alpha);
      end
      if (beta > ONE_S) begin
         be1_in = AL_W'(ONE_S);
      end else if (beta < MONE_S) begin
         be1_in = AL_W'(MONE_S);
      end else begin
         be1_in = AL_W'(beta);
      end
   end

   always_comb begin
      prod          = MUL_W'(al1_ff) * C_S;
      al_m          = AL_W'(prod >>> FRAC_BITS);
      be_h          = be1_ff >>> 1;
      proj_in.valid = v1_ff;
      proj_in.pi    = P_W'(al_m) - P_W'(be_h);
      proj_in.pj    = P_W'(be1_ff);
      proj_in.pk    = -P_W'(al_m) - P_W'(be_h);
      proj_in.sector = sector_type'({~proj_in.pk[P_W-1], ~proj_in.pj[P_W-1],
                                     ~proj_in.pi[P_W-1]});
      proj_in.signs = sg1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         proj_ff.valid <= 1'b0;
      end else begin
         v1_ff   <= v1_in;
         proj_ff <= proj_in;
      end
   end

   always_ff @(posedge clock) begin
      al1_ff <= al1_in;
      be1_ff <= be1_in;
      sg1_ff <= signs;
   end

   assign proj = proj_ff;

endmodule

### hdl/svmab_times.sv
module svmab_times
   import svmab_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  proj_type proj,
   output time_type times
);

   localparam logic signed [S_W-1:0] FULL_ONE = S_W'(FULL_SCALE * ONE);

   logic                  v3_ff;
   sector_type            sec3_ff;
   sign_set_type          sg3_ff;
   logic signed [T_W-1:0] t1_ff, t1_in;
   logic signed [T_W-1:0] t2_ff, t2_in;
   logic signed [P_W-1:0] p1, p2;
   time_type              times_ff, times_in;
   logic signed [S_W-1:0] zero_t;

   always_comb begin
      case (proj.sector)
         SEC_IJ: begin
            p1 = proj.pi;
            p2 = proj.pj;
         end
         SEC_J: begin
            p1 = -proj.pk;
            p2 = -proj.pi;
         end
         SEC_JK: begin
            p1 = proj.pj;
            p2 = proj.pk;
         end
         SEC_K: begin
            p1 = -proj.pi;
            p2 = -proj.pj;
         end
         SEC_IK: begin
            p1 = proj.pk;
            p2 = proj.pi;
         end
         SEC_I: begin
            p1 = -proj.pj;
            p2 = -proj.pk;
         end
         default: begin
            p1 = '0;
            p2 = '0;
         end
      endcase
      t1_in = (T_W'(p1) <<< DUTY_W) - T_W'(p1);
      t2_in = (T_W'(p2) <<< DUTY_W) - T_W'(p2);
   end

   always_comb begin
      zero_t          = FULL_ONE - S_W'(t1_ff) - S_W'(t2_ff);
      times_in.valid  = v3_ff;
      times_in.sector = sec3_ff;
      times_in.t1     = t1_ff;
      times_in.t2     = t2_ff;
      times_in.h      = zero_t >>> 1;
      times_in.signs  = sg3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff          <= 1'b0;
         times_ff.valid <= 1'b0;
      end else begin
         v3_ff    <= proj.valid;
         times_ff <= times_in;
      end
   end

   always_ff @(posedge clock) begin
      sec3_ff <= proj.sector;
      sg3_ff  <= proj.signs;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
   end

   assign times = times_ff;

endmodule

### hdl/svmab_comp.sv
module svmab_comp
   import svmab_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  time_type          times,
   input  logic [DUTY_W-1:0] dead_time,
   output logic              out_valid,
   output logic [DUTY_W-1:0] duty_a,
   output logic [DUTY_W-1:0] duty_b,
   output logic [DUTY_W-1:0] duty_c
);

   localparam logic signed [N_W-1:0] FULL_N = N_W'(FULL_SCALE);

   logic                  v5_ff;
   sign_set_type          sg5_ff;
   logic signed [S_W-1:0] fa_ff, fa_in;
   logic signed [S_W-1:0] fb_ff, fb_in;
   logic signed [S_W-1:0] fc_ff, fc_in;
   logic signed [S_W-1:0] sum_all, sum_1, sum_2;
   logic                  v6_ff;
   logic [DUTY_W-1:0]     da_ff, db_ff, dc_ff;

   function automatic logic [DUTY_W-1:0] finish(input logic signed [S_W-1:0] f,
                                                input logic [SIGN_W-1:0]   sgn,
                                                input logic [DUTY_W-1:0]   dt);
      logic signed [N_W-1:0] n;
      logic signed [N_W-1:0] dts;
      dts = N_W'({1'b0, dt});
      n   = N_W'(f >>> FRAC_BITS);
      if (sgn == SIGN_POS) begin
         n = n + dts;
      end else if (sgn[SIGN_W-1]) begin
         n = n - dts;
      end
      if (n > FULL_N) begin
         finish = DUTY_W'(FULL_SCALE);
      end else if (n < 0) begin
         finish = '0;
      end else begin
         finish = DUTY_W'(n);
      end
   endfunction

   always_comb begin
      sum_1   = S_W'(times.t1) + times.h;
      sum_2   = S_W'(times.t2) + times.h;
      sum_all = S_W'(times.t1) + sum_2;
      case (times.sector)
         SEC_IJ: begin
            fa_in = sum_all;
            fb_in = sum_2;
            fc_in = times.h;
         end
         SEC_J: begin
            fa_in = sum_1;
            fb_in = sum_all;
            fc_in = times.h;
         end
         SEC_JK: begin
            fa_in = times.h;
            fb_in = sum_all;
            fc_in = sum_2;
         end
         SEC_K: begin
            fa_in = times.h;
            fb_in = sum_1;
            fc_in = sum_all;
         end
         SEC_IK: begin
            fa_in = sum_2;
            fb_in = times.h;
            fc_in = sum_all;
         end
         SEC_I: begin
            fa_in = sum_all;
            fb_in = times.h;
            fc_in = sum_1;
         end
         default: begin
            fa_in = times.h;
            fb_in = times.h;
            fc_in = times.h;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v5_ff <= times.valid;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      sg5_ff <= times.signs;
      fa_ff  <= fa_in;
      fb_ff  <= fb_in;
      fc_ff  <= fc_in;
      da_ff  <= finish(fa_ff, sg5_ff.a, dead_time);
      db_ff  <= finish(fb_ff, sg5_ff.b, dead_time);
      dc_ff  <= finish(fc_ff, sg5_ff.c, dead_time);
   end

   assign out_valid = v6_ff;
   assign duty_a    = da_ff;
   assign duty_b    = db_ff;
   assign duty_c    = dc_ff;

endmodule
